// ===== rtl/arc_ring_hit_test_top_defines.svh =====
// Assertion macros for the arc ring hit test block.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef ARC_RING_HIT_TEST_TOP_DEFINES_SVH
`define ARC_RING_HIT_TEST_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ARHT_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("arht: concurrent check failed");

// Next-cycle implication, disabled during reset
`define ARHT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("arht: concurrent check failed");

`endif

// ===== rtl/arht_pkg.sv =====
// Shared widths, constants, register codes and stage payload types
// for the arc ring hit test block. No dependencies.
package arht_pkg;

   localparam int COORD_W     = 16;  // Q12.4 coordinate / width fields
   localparam int DIFF_W      = 17;  // point minus center
   localparam int SQ_W        = 32;  // one squared difference
   localparam int D2_W        = 33;  // sum of two squares
   localparam int CORD_W      = 40;  // CORDIC x/y datapath
   localparam int Z_W         = 33;  // angle accumulator, 2^-16 of 1/64 degree
   localparam int ANG_W       = 16;  // angle in 1/64 degree
   localparam int WANG_W      = 18;  // angle after wrap into [0, 360)
   localparam int PRE_SHIFT   = 20;  // scale of the vector before rotation
   localparam int ROUND_SHIFT = 16;  // accumulator fraction bits
   localparam int RZ_W        = Z_W - ROUND_SHIFT;
   localparam int TAB_LEN     = 24;
   localparam int ANG_HALF    = 11520;
   localparam int ANG_FULL    = 23040;
   localparam int CSR_IDX_W   = 3;

   localparam logic signed [Z_W-1:0] Z_HALF  = Z_W'(ANG_HALF) <<< ROUND_SHIFT;
   localparam logic signed [Z_W-1:0] Z_ROUND = Z_W'(1) <<< (ROUND_SHIFT - 1);

   // atan(2^-i) in 2^-16 of 1/64 degree
   localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
      32'd188743680, 32'd111421900, 32'd58872272, 32'd29884485,
      32'd15000234,  32'd7507429,   32'd3754631,  32'd1877430,
      32'd938729,    32'd469366,    32'd234683,   32'd117342,
      32'd58671,     32'd29335,     32'd14668,    32'd7334,
      32'd3667,      32'd1833,      32'd917,      32'd458,
      32'd229,       32'd115,       32'd57,       32'd29
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X     = 3'd0,
      CSR_CENTER_Y     = 3'd1,
      CSR_OUTER_RADIUS = 3'd2,
      CSR_BAND_WIDTH   = 3'd3,
      CSR_START_ANGLE  = 3'd4,
      CSR_SWEEP_ANGLE  = 3'd5,
      CSR_LEFT_MODE    = 3'd6
   } csr_index_type;

   // Register contents plus values derived from them
   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic        [COORD_W-1:0] outer_radius;
      logic        [COORD_W-1:0] band_width;
      logic signed [ANG_W-1:0]   start_angle;
      logic signed [ANG_W:0]     end_angle;    // start + sweep
      logic signed [WANG_W-1:0]  start_wrap;   // left rule, wrapped start
      logic signed [WANG_W-1:0]  end_wrap;     // left rule, wrapped end
      logic                      left_mode;
      logic        [SQ_W-1:0]    outer_sq;
   } cfg_type;

   // Item moving through the rotation stages
   typedef struct packed {
      logic signed [CORD_W-1:0] x;
      logic signed [CORD_W-1:0] y;
      logic signed [Z_W-1:0]    z;
      logic                     zero;  // point sits on the center
      logic                     band;  // radial test result
   } cord_type;

endpackage

// ===== rtl/arht_req_if.sv =====
// Query channel: point and minimum hot width, valid/ready handshake.
// Depends on arht_pkg.
interface arht_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [arht_pkg::COORD_W-1:0] point_x;
   logic signed [arht_pkg::COORD_W-1:0] point_y;
   logic        [arht_pkg::COORD_W-1:0] min_hot_width;

   modport source (output valid, point_x, point_y, min_hot_width, input ready);
   modport sink   (input valid, point_x, point_y, min_hot_width, output ready);
endinterface

// ===== rtl/arht_rsp_if.sv =====
// Result channel: hit and in_band flags, valid/ready handshake.
// No dependencies.
interface arht_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic in_band;

   modport source (output valid, hit, in_band, input ready);
   modport sink   (input valid, hit, in_band, output ready);
endinterface

// ===== rtl/arht_csr_if.sv =====
// Register write channel: index and data, valid/ready handshake.
// Depends on arht_pkg.
interface arht_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [arht_pkg::CSR_IDX_W-1:0]        index;
   logic [arht_pkg::COORD_W-1:0]          data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/arht_csr.sv =====
// Configuration registers and the values derived from them.
// Depends on arht_pkg and arht_csr_if.
module arht_csr (
   input  logic              clock,
   input  logic              reset,
   arht_csr_if.sink          csr_chan,
   output arht_pkg::cfg_type cfg
);

   logic signed [arht_pkg::COORD_W-1:0] center_x_ff;
   logic signed [arht_pkg::COORD_W-1:0] center_y_ff;
   logic        [arht_pkg::COORD_W-1:0] outer_radius_ff;
   logic        [arht_pkg::COORD_W-1:0] band_width_ff;
   logic signed [arht_pkg::ANG_W-1:0]   start_angle_ff;
   logic signed [arht_pkg::ANG_W-1:0]   sweep_angle_ff;
   logic                                left_mode_ff;

   logic signed [arht_pkg::ANG_W:0]    end_angle_ff, end_angle_in;
   logic signed [arht_pkg::WANG_W-1:0] start_wrap_ff, start_wrap_in;
   logic signed [arht_pkg::WANG_W-1:0] end_wrap_ff, end_wrap_in;
   logic        [arht_pkg::SQ_W-1:0]   outer_sq_ff, outer_sq_in;
   logic signed [arht_pkg::WANG_W-1:0] end_left;
   logic signed [arht_pkg::WANG_W-1:0] end_wide;

   assign csr_chan.ready = 1'b1;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         outer_radius_ff <= '0;
         band_width_ff   <= '0;
         start_angle_ff  <= '0;
         sweep_angle_ff  <= '0;
         left_mode_ff    <= 1'b0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (arht_pkg::csr_index_type'(csr_chan.index))
            arht_pkg::CSR_CENTER_X:     center_x_ff     <= csr_chan.data;
            arht_pkg::CSR_CENTER_Y:     center_y_ff     <= csr_chan.data;
            arht_pkg::CSR_OUTER_RADIUS: outer_radius_ff <= csr_chan.data;
            arht_pkg::CSR_BAND_WIDTH:   band_width_ff   <= csr_chan.data;
            arht_pkg::CSR_START_ANGLE:  start_angle_ff  <= csr_chan.data;
            arht_pkg::CSR_SWEEP_ANGLE:  sweep_angle_ff  <= csr_chan.data;
            arht_pkg::CSR_LEFT_MODE:    left_mode_ff    <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   // Arc end and wrapped limits for the left rule
   always_comb begin
      end_angle_in = $signed((arht_pkg::ANG_W + 1)'(start_angle_ff))
                   + $signed((arht_pkg::ANG_W + 1)'(sweep_angle_ff));
      end_wide = $signed(arht_pkg::WANG_W'(end_angle_in));
      if (end_wide <= -$signed(arht_pkg::WANG_W'(arht_pkg::ANG_HALF))) begin
         end_left = end_wide + $signed(arht_pkg::WANG_W'(arht_pkg::ANG_FULL));
      end else begin
         end_left = end_wide;
      end
      end_wrap_in = end_left[arht_pkg::WANG_W-1]
                  ? end_left + $signed(arht_pkg::WANG_W'(arht_pkg::ANG_FULL)) : end_left;
      start_wrap_in = $signed(arht_pkg::WANG_W'(start_angle_ff));
      if (start_angle_ff[arht_pkg::ANG_W-1]) begin
         start_wrap_in = start_wrap_in + $signed(arht_pkg::WANG_W'(arht_pkg::ANG_FULL));
      end
      outer_sq_in = outer_radius_ff * outer_radius_ff;
   end

   // Derived values are registered, so they settle in the cycle after a write
   always_ff @(posedge clock) begin
      if (reset) begin
         end_angle_ff  <= '0;
         start_wrap_ff <= '0;
         end_wrap_ff   <= '0;
         outer_sq_ff   <= '0;
      end else begin
         end_angle_ff  <= end_angle_in;
         start_wrap_ff <= start_wrap_in;
         end_wrap_ff   <= end_wrap_in;
         outer_sq_ff   <= outer_sq_in;
      end
   end

   always_comb begin
      cfg.center_x     = center_x_ff;
      cfg.center_y     = center_y_ff;
      cfg.outer_radius = outer_radius_ff;
      cfg.band_width   = band_width_ff;
      cfg.start_angle  = start_angle_ff;
      cfg.end_angle    = end_angle_ff;
      cfg.start_wrap   = start_wrap_ff;
      cfg.end_wrap     = end_wrap_ff;
      cfg.left_mode    = left_mode_ff;
      cfg.outer_sq     = outer_sq_ff;
   end

endmodule

// ===== rtl/arht_front.sv =====
// Front stages: offset from center, radial band test, half-plane fold.
// Four register stages. Depends on arht_pkg.
module arht_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [arht_pkg::COORD_W-1:0] point_x,
   input  logic signed [arht_pkg::COORD_W-1:0] point_y,
   input  logic        [arht_pkg::COORD_W-1:0] min_hot_width,
   input  arht_pkg::cfg_type                   cfg,
   output logic                                out_valid,
   input  logic                                out_ready,
   output arht_pkg::cord_type                  out_data
);

   localparam int DW = arht_pkg::DIFF_W;
   localparam int CW = arht_pkg::COORD_W;

   // stage A
   logic                 a_valid_ff;
   logic signed [DW-1:0] a_dx_ff, a_dy_ff, a_dx_in, a_dy_in;
   logic        [CW-1:0] a_w_ff, a_w_in;
   // stage B
   logic                          b_valid_ff;
   logic signed [DW-1:0]          b_x_ff, b_y_ff, b_x_in, b_y_in;
   logic signed [arht_pkg::Z_W-1:0] b_z_ff, b_z_in;
   logic                          b_zero_ff, b_zero_in;
   logic [arht_pkg::SQ_W-1:0]     b_sqx_ff, b_sqy_ff;
   logic signed [2*DW-1:0]        b_sqx_in, b_sqy_in;
   logic signed [DW-1:0]          b_inner_ff, b_inner_in;
   // stage C
   logic                          c_valid_ff;
   logic signed [DW-1:0]          c_x_ff, c_y_ff;
   logic signed [arht_pkg::Z_W-1:0] c_z_ff;
   logic                          c_zero_ff;
   logic [arht_pkg::D2_W-1:0]     c_d2_ff, c_d2_in;
   logic                          c_inner_pos_ff, c_inner_pos_in;
   logic [arht_pkg::SQ_W-1:0]     c_inner_sq_ff, c_inner_sq_in;
   // stage D
   logic                          d_valid_ff;
   arht_pkg::cord_type            d_data_ff, d_data_in;

   logic rdy_a, rdy_b, rdy_c, rdy_d;

   // Each stage moves when it is empty or the next one moves
   assign rdy_d    = !d_valid_ff || out_ready;
   assign rdy_c    = !c_valid_ff || rdy_d;
   assign rdy_b    = !b_valid_ff || rdy_c;
   assign rdy_a    = !a_valid_ff || rdy_b;
   assign in_ready = rdy_a;

   // A: offsets and effective band width
   always_comb begin
      a_dx_in = $signed(DW'(point_x)) - $signed(DW'(cfg.center_x));
      a_dy_in = $signed(DW'(point_y)) - $signed(DW'(cfg.center_y));
      a_w_in  = (min_hot_width > cfg.band_width) ? min_hot_width : cfg.band_width;
   end

   // B: squares, inner radius, fold into the right half plane
   always_comb begin
      b_sqx_in   = a_dx_ff * a_dx_ff;
      b_sqy_in   = a_dy_ff * a_dy_ff;
      b_inner_in = $signed({1'b0, cfg.outer_radius}) - $signed({1'b0, a_w_ff});
      b_zero_in  = (a_dx_ff == '0) && (a_dy_ff == '0);
      if (a_dx_ff[DW-1]) begin
         b_x_in = -a_dx_ff;
         b_y_in = -a_dy_ff;
         b_z_in = a_dy_ff[DW-1] ? -arht_pkg::Z_HALF : arht_pkg::Z_HALF;
      end else begin
         b_x_in = a_dx_ff;
         b_y_in = a_dy_ff;
         b_z_in = '0;
      end
   end

   // C: squared distance and squared inner radius
   always_comb begin
      c_d2_in        = {1'b0, b_sqx_ff} + {1'b0, b_sqy_ff};
      c_inner_pos_in = !b_inner_ff[DW-1] && (b_inner_ff != '0);
      c_inner_sq_in  = b_inner_ff[CW-1:0] * b_inner_ff[CW-1:0];
   end

   // D: band decision, vector scaled for the rotation stages
   always_comb begin
      d_data_in.x    = $signed(arht_pkg::CORD_W'(c_x_ff)) <<< arht_pkg::PRE_SHIFT;
      d_data_in.y    = $signed(arht_pkg::CORD_W'(c_y_ff)) <<< arht_pkg::PRE_SHIFT;
      d_data_in.z    = c_z_ff;
      d_data_in.zero = c_zero_ff;
      d_data_in.band = (c_d2_ff <= {1'b0, cfg.outer_sq})
                     && !(c_inner_pos_ff && (c_d2_ff < {1'b0, c_inner_sq_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (rdy_a) a_valid_ff <= in_valid;
         if (rdy_b) b_valid_ff <= a_valid_ff;
         if (rdy_c) c_valid_ff <= b_valid_ff;
         if (rdy_d) d_valid_ff <= c_valid_ff;
      end
      if (rdy_a) begin
         a_dx_ff <= a_dx_in;
         a_dy_ff <= a_dy_in;
         a_w_ff  <= a_w_in;
      end
      if (rdy_b) begin
         b_x_ff     <= b_x_in;
         b_y_ff     <= b_y_in;
         b_z_ff     <= b_z_in;
         b_zero_ff  <= b_zero_in;
         b_sqx_ff   <= b_sqx_in[arht_pkg::SQ_W-1:0];
         b_sqy_ff   <= b_sqy_in[arht_pkg::SQ_W-1:0];
         b_inner_ff <= b_inner_in;
      end
      if (rdy_c) begin
         c_x_ff         <= b_x_ff;
         c_y_ff         <= b_y_ff;
         c_z_ff         <= b_z_ff;
         c_zero_ff      <= b_zero_ff;
         c_d2_ff        <= c_d2_in;
         c_inner_pos_ff <= c_inner_pos_in;
         c_inner_sq_ff  <= c_inner_sq_in;
      end
      if (rdy_d) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

// ===== rtl/arht_cordic.sv =====
// Vectoring CORDIC: one rotation per register stage, atan sums into z.
// Depends on arht_pkg.
module arht_cordic #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  arht_pkg::cord_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output arht_pkg::cord_type out_data
);

   logic               valid_ff [STAGES];
   logic               valid_in [STAGES];
   logic               ready    [STAGES+1];
   arht_pkg::cord_type data_ff  [STAGES];
   arht_pkg::cord_type stage_in [STAGES];
   arht_pkg::cord_type data_in  [STAGES];

   assign ready[STAGES] = out_ready;
   assign in_ready      = ready[0];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign stage_in[i] = in_data;
         assign valid_in[i] = in_valid;
      end else begin : g_next
         assign stage_in[i] = data_ff[i-1];
         assign valid_in[i] = valid_ff[i-1];
      end

      assign ready[i] = !valid_ff[i] || ready[i+1];

      // Rotate toward the x axis by atan(2^-i)
      always_comb begin
         data_in[i] = stage_in[i];
         if (!stage_in[i].y[arht_pkg::CORD_W-1]) begin
            data_in[i].x = stage_in[i].x + (stage_in[i].y >>> i);
            data_in[i].y = stage_in[i].y - (stage_in[i].x >>> i);
            data_in[i].z = stage_in[i].z + $signed(arht_pkg::Z_W'(arht_pkg::ATAN_TAB[i]));
         end else begin
            data_in[i].x = stage_in[i].x - (stage_in[i].y >>> i);
            data_in[i].y = stage_in[i].y + (stage_in[i].x >>> i);
            data_in[i].z = stage_in[i].z - $signed(arht_pkg::Z_W'(arht_pkg::ATAN_TAB[i]));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ready[i]) begin
            valid_ff[i] <= valid_in[i];
         end
         if (ready[i]) begin
            data_ff[i] <= data_in[i];
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = data_ff[STAGES-1];

endmodule

// ===== rtl/arht_post.sv =====
// Back stages: round and clamp the angle, then the sector test and
// the result register. Depends on arht_pkg.
module arht_post (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  arht_pkg::cord_type in_data,
   input  arht_pkg::cfg_type  cfg,
   output logic               out_valid,
   input  logic               out_ready,
   output logic               hit,
   output logic               in_band
);

   localparam int AW = arht_pkg::ANG_W;
   localparam int WW = arht_pkg::WANG_W;
   localparam int RW = arht_pkg::RZ_W;

   logic                    e_valid_ff;
   logic signed [AW-1:0]    e_ang_ff, e_ang_in;
   logic                    e_band_ff;
   logic signed [arht_pkg::Z_W-1:0] z_round;
   logic signed [RW-1:0]    z_deg;

   logic                    f_valid_ff;
   logic                    f_hit_ff, f_hit_in;
   logic                    f_band_ff;
   logic signed [WW-1:0]    ang_wide, ang_wrap, end_wide;
   logic                    ang_ok;

   logic rdy_e, rdy_f;

   assign rdy_f    = !f_valid_ff || out_ready;
   assign rdy_e    = !e_valid_ff || rdy_f;
   assign in_ready = rdy_e;

   // E: round half up to 1/64 degree, clamp to +/-180 degrees
   always_comb begin
      z_round = in_data.z + arht_pkg::Z_ROUND;
      z_deg   = RW'(z_round >>> arht_pkg::ROUND_SHIFT);
      if (in_data.zero) begin
         e_ang_in = '0;
      end else if (z_deg > $signed(RW'(arht_pkg::ANG_HALF))) begin
         e_ang_in = $signed(AW'(arht_pkg::ANG_HALF));
      end else if (z_deg < -$signed(RW'(arht_pkg::ANG_HALF))) begin
         e_ang_in = -$signed(AW'(arht_pkg::ANG_HALF));
      end else begin
         e_ang_in = AW'(z_deg);
      end
   end

   // F: sector test, normal or wrapped left rule
   always_comb begin
      ang_wide = $signed(WW'(e_ang_ff));
      end_wide = $signed(WW'(cfg.end_angle));
      ang_wrap = e_ang_ff[AW-1] ? ang_wide + $signed(WW'(arht_pkg::ANG_FULL)) : ang_wide;
      if (cfg.left_mode) begin
         ang_ok = !((ang_wrap < cfg.end_wrap) || (ang_wrap > cfg.start_wrap));
      end else begin
         ang_ok = !((ang_wide < $signed(WW'(cfg.start_angle))) || (ang_wide > end_wide));
      end
      f_hit_in = e_band_ff && ang_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         if (rdy_e) e_valid_ff <= in_valid;
         if (rdy_f) f_valid_ff <= e_valid_ff;
      end
      if (rdy_e) begin
         e_ang_ff  <= e_ang_in;
         e_band_ff <= in_data.band;
      end
      if (rdy_f) begin
         f_hit_ff  <= f_hit_in;
         f_band_ff <= e_band_ff;
      end
   end

   assign out_valid = f_valid_ff;
   assign hit       = f_hit_ff;
   assign in_band   = f_band_ff;

endmodule

// ===== rtl/arc_ring_hit_test_top.sv =====
// Arc ring hit test. Top level; depends on arht_pkg, the channel interfaces,
// arht_csr, arht_front, arht_cordic and arht_post.
//
// Takes one query point per clock when no stall holds the pipeline, and answers,
// for each, whether it lies in the ring band (squared distance between inner
// and outer radius) and whether it also falls inside the arc's angular sector.
// Throughput is one item per cycle when not stalled. Items pass through four
// front stages (offset, squares, sum, band compare), one CORDIC rotation per
// register stage, and two back stages (angle rounding, sector test into the
// result register). Every stage holds its item on a stall and empty stages
// keep filling, so new items are taken while a result waits. Register writes
// take effect once the registered sector limits and squared outer radius are
// refreshed from them. Stage counts above 24 are cut to 24.
`include "arc_ring_hit_test_top_defines.svh"

module arc_ring_hit_test_top #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic      clock,
   input  logic      reset,
   arht_req_if.sink  req_chan,
   arht_rsp_if.source rsp_chan,
   arht_csr_if.sink  csr_chan
);

   localparam int STAGES = (CORDIC_STAGES < arht_pkg::TAB_LEN)
                         ? CORDIC_STAGES : arht_pkg::TAB_LEN;

   arht_pkg::cfg_type  cfg;
   logic               fr_valid, fr_ready;
   arht_pkg::cord_type fr_data;
   logic               cd_valid, cd_ready;
   arht_pkg::cord_type cd_data;

   // Register file
   arht_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // Offset, band test, fold
   arht_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_chan.valid),
      .in_ready      (req_chan.ready),
      .point_x       (req_chan.point_x),
      .point_y       (req_chan.point_y),
      .min_hot_width (req_chan.min_hot_width),
      .cfg           (cfg),
      .out_valid     (fr_valid),
      .out_ready     (fr_ready),
      .out_data      (fr_data)
   );

   // Angle by rotation
   arht_cordic #(
      .STAGES (STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (cd_valid),
      .out_ready (cd_ready),
      .out_data  (cd_data)
   );

   // Rounding, sector test, result register
   arht_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cd_valid),
      .in_ready  (cd_ready),
      .in_data   (cd_data),
      .cfg       (cfg),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .hit       (rsp_chan.hit),
      .in_band   (rsp_chan.in_band)
   );

   // A stalled front item must reach the rotation stages unchanged
   `ARHT_ASSERT_NEXT(a_front_hold, fr_valid && !fr_ready, fr_valid && $stable(fr_data))
   // Same at the rotation output
   `ARHT_ASSERT_NEXT(a_cordic_hold, cd_valid && !cd_ready, cd_valid && $stable(cd_data))
   // A hit is always inside the band
   `ARHT_ASSERT(a_hit_band, rsp_chan.valid, !rsp_chan.hit || rsp_chan.in_band)

endmodule

// ===== bench/tb_arc_ring_hit_test_top.sv =====
// Testbench for arc_ring_hit_test_top: directed table then randomized phases,
// every result checked against a local ring/sector hit predictor or a typed verdict.
// Depends on arht_pkg, the req/rsp/csr channel interfaces and the RTL top.
module tb_arc_ring_hit_test_top;

   localparam int CORDIC_STAGES = 16;
   localparam int CLK_PERIOD    = 12;
   localparam int PIPE_LATENCY  = CORDIC_STAGES + 6;
   localparam int RAND_PHASES   = 12;
   localparam int PHASE_ITEMS   = 100;
   localparam int HOLD_CYCLES   = 300;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int DIR_ROWS      = 42;
   localparam int COORD_W       = arht_pkg::COORD_W;
   localparam int ANG_W         = arht_pkg::ANG_W;
   localparam int CSR_IDX_W     = arht_pkg::CSR_IDX_W;
   localparam int ANG_HALF      = arht_pkg::ANG_HALF;
   localparam int ANG_FULL      = arht_pkg::ANG_FULL;
   localparam int ROUND_SHIFT   = arht_pkg::ROUND_SHIFT;
   localparam int PRE_SHIFT     = arht_pkg::PRE_SHIFT;
   localparam int TAB_LEN       = arht_pkg::TAB_LEN;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNUSED = 3'd7;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;
   typedef enum logic {ROW_WRITE, ROW_QUERY} row_kind_type;

   typedef struct packed {
      logic hit;
      logic in_band;
   } verdict_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_IDX_W-1:0]      index;
      logic [COORD_W-1:0]        data;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic [COORD_W-1:0]        hot;
      bit                        typed;  // use the verdict below, not the predictor
      verdict_type               want;
   } stim_row_type;

   logic clock;
   logic reset;

   arht_req_if req_chan ();
   arht_rsp_if rsp_chan ();
   arht_csr_if csr_chan ();

   arc_ring_hit_test_top #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Register image as the block should hold it
   logic signed [COORD_W-1:0] cfg_center_x = '0;
   logic signed [COORD_W-1:0] cfg_center_y = '0;
   logic        [COORD_W-1:0] cfg_outer    = '0;
   logic        [COORD_W-1:0] cfg_band     = '0;
   logic signed [ANG_W-1:0]   cfg_start    = '0;
   logic signed [ANG_W-1:0]   cfg_sweep    = '0;
   logic                      cfg_left     = 1'b0;

   verdict_type pending_verdicts [$];
   int          fail_count     = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          rsp_hold_left  = 0;
   bit          need_drain     = 1'b0;

   // Directed items: reset values, extremes, sector edges, wrap rules
   stim_row_type dir_rows [DIR_ROWS] = '{
      // reset config: only the center itself lies in a zero-radius ring
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd0, 16'sd0, 16'h0000, 1'b1, 2'b11},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd16, 16'sd0, 16'h0000, 1'b1, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sh8000, 16'sh8000, 16'hFFFF, 1'b1,
        2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b1,
        2'b00},
      // ring 8..10 px, first quadrant
      '{ROW_WRITE, arht_pkg::CSR_CENTER_X,     16'd0,    '0, '0, '0, 1'b0, 2'b00},
      '{ROW_WRITE, arht_pkg::CSR_CENTER_Y,     16'd0,    '0, '0, '0, 1'b0, 2'b00},
      '{ROW_WRITE, arht_pkg::CSR_OUTER_RADIUS, 16'd160,  '0, '0, '0, 1'b0, 2'b00},
      '{ROW_WRITE, arht_pkg::CSR_BAND_WIDTH,   16'd32,   '0, '0, '0, 1'b0, 2'b00},
      '{ROW_WRITE, arht_pkg::CSR_START_ANGLE,  16'd0,    '0, '0, '0, 1'b0, 2'b00},
      '{ROW_WRITE, arht_pkg::CSR_SWEEP_ANGLE,  16'd5760, '0, '0, '0, 1'b0, 2'b00},
      '{ROW_WRITE, arht_pkg::CSR_LEFT_MODE,    16'd0,    '0, '0, '0, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd150, 16'sd0, 16'h0000, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd0, 16'sd150, 16'h0000, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, -16'sd150, 16'sd0, 16'h0000, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd0, -16'sd150, 16'h0000, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd100, 16'sd50, 16'h0000, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd100, 16'sd0, 16'hFFFF, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd160, 16'sd0, 16'h0000, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd128, 16'sd0, 16'h0000, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd106, 16'sd106, 16'h0000, 1'b0,
        2'b00},
      // negative sweep in normal mode never passes the angle test
      '{ROW_WRITE, arht_pkg::CSR_SWEEP_ANGLE, -16'sd5760, '0, '0, '0, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd150, 16'sd0, 16'h0000, 1'b1, 2'b01},
      // left rule, -90 down to -135 degrees
      '{ROW_WRITE, arht_pkg::CSR_LEFT_MODE,   16'd1,      '0, '0, '0, 1'b0, 2'b00},
      '{ROW_WRITE, arht_pkg::CSR_START_ANGLE, -16'sd5760, '0, '0, '0, 1'b0, 2'b00},
      '{ROW_WRITE, arht_pkg::CSR_SWEEP_ANGLE, -16'sd2880, '0, '0, '0, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, -16'sd100, -16'sd100, 16'h0000, 1'b0,
        2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd0, -16'sd150, 16'h0000, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd150, 16'sd0, 16'h0000, 1'b0, 2'b00},
      // left rule with end at or below -180, wrapped up by a full turn
      '{ROW_WRITE, arht_pkg::CSR_START_ANGLE, -16'sd11520, '0, '0, '0, 1'b0, 2'b00},
      '{ROW_WRITE, arht_pkg::CSR_SWEEP_ANGLE, -16'sd5760,  '0, '0, '0, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd0, 16'sd150, 16'h0000, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, -16'sd150, 16'sd0, 16'h0000, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, -16'sd150, -16'sd1, 16'h0000, 1'b0,
        2'b00},
      // write to an index past the register list is dropped
      '{ROW_WRITE, CSR_IDX_UNUSED, 16'hFFFF, '0, '0, '0, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sd0, 16'sd150, 16'h0000, 1'b0, 2'b00},
      // extreme center and radius
      '{ROW_WRITE, arht_pkg::CSR_CENTER_X,     16'h8000, '0, '0, '0, 1'b0, 2'b00},
      '{ROW_WRITE, arht_pkg::CSR_CENTER_Y,     16'h7FFF, '0, '0, '0, 1'b0, 2'b00},
      '{ROW_WRITE, arht_pkg::CSR_OUTER_RADIUS, 16'hFFFF, '0, '0, '0, 1'b0, 2'b00},
      '{ROW_WRITE, arht_pkg::CSR_BAND_WIDTH,   16'h0000, '0, '0, '0, 1'b0, 2'b00},
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sh7FFF, 16'sh8000, 16'h0000, 1'b0,
        2'b00},
      // center inside a full-radius inner bound is outside the band
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sh8000, 16'sh7FFF, 16'h0000, 1'b1,
        2'b00},
      // hot width equal to the radius drops the inner bound
      '{ROW_QUERY, arht_pkg::CSR_CENTER_X, 16'h0000, 16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b0,
        2'b00}
   };

   // Expected hit and band flags for one point under the current registers
   function automatic verdict_type arc_hit_predict(input logic signed [COORD_W-1:0] px,
                                                   input logic signed [COORD_W-1:0] py,
                                                   input logic [COORD_W-1:0]        hot);
      longint      dx, dy, x, y, z, nx, ny;
      longint      outer, width, inner, dist_sq;
      int          ang, st, en;
      bit          sector_ok;
      verdict_type v;
      dx    = longint'(px) - longint'(cfg_center_x);
      dy    = longint'(py) - longint'(cfg_center_y);
      outer = longint'(cfg_outer);
      width = (longint'(hot) > longint'(cfg_band)) ? longint'(hot) : longint'(cfg_band);
      inner = outer - width;
      dist_sq = dx * dx + dy * dy;
      v.in_band = (dist_sq <= outer * outer);
      if (inner > 0 && dist_sq < inner * inner) v.in_band = 1'b0;

      // CORDIC vectoring, after folding into the right half plane
      if (dx == 0 && dy == 0) begin
         ang = 0;
      end else begin
         z = 0;
         if (dx < 0) begin
            z  = (dy >= 0) ? (longint'(ANG_HALF) <<< ROUND_SHIFT)
                           : -(longint'(ANG_HALF) <<< ROUND_SHIFT);
            dx = -dx;
            dy = -dy;
         end
         x = dx <<< PRE_SHIFT;
         y = dy <<< PRE_SHIFT;
         for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
            if (y >= 0) begin
               nx = x + (y >>> i);
               ny = y - (x >>> i);
               z  = z + longint'(arht_pkg::ATAN_TAB[i]);
            end else begin
               nx = x - (y >>> i);
               ny = y + (x >>> i);
               z  = z - longint'(arht_pkg::ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
         end
         z = (z + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
         if (z > ANG_HALF) z = ANG_HALF;
         if (z < -ANG_HALF) z = -ANG_HALF;
         ang = int'(z);
      end

      // Sector test, normal or wrapped left rule
      st = int'(cfg_start);
      en = st + int'(cfg_sweep);
      if (cfg_left) begin
         if (en <= -ANG_HALF) en += ANG_FULL;
         if (st < 0) st += ANG_FULL;
         if (en < 0) en += ANG_FULL;
         if (ang < 0) ang += ANG_FULL;
         sector_ok = !(ang < en || ang > st);
      end else begin
         sector_ok = !(ang < st || ang > en);
      end
      v.hit = v.in_band && sector_ok;
      return v;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   // Register write; first waits until no query is in flight
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
      if (need_drain) begin
         req_chan.valid <= 1'b0;
         while (pending_verdicts.size() != 0) @(posedge clock);
         need_drain = 1'b0;
      end
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         arht_pkg::CSR_CENTER_X:     cfg_center_x = val;
         arht_pkg::CSR_CENTER_Y:     cfg_center_y = val;
         arht_pkg::CSR_OUTER_RADIUS: cfg_outer    = val;
         arht_pkg::CSR_BAND_WIDTH:   cfg_band     = val;
         arht_pkg::CSR_START_ANGLE:  cfg_start    = val;
         arht_pkg::CSR_SWEEP_ANGLE:  cfg_sweep    = val;
         arht_pkg::CSR_LEFT_MODE:    cfg_left     = val[0];
         default: ;
      endcase
   endtask

   // Offer one query item, with random idle cycles ahead of it
   task automatic send_query(input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py,
                             input logic [COORD_W-1:0]        hot,
                             input bit                        typed,
                             input verdict_type               want);
      verdict_type v;
      csr_chan.valid <= 1'b0;
      need_drain = 1'b1;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      v = typed ? want : arc_hit_predict(px, py, hot);
      req_chan.valid         <= 1'b1;
      req_chan.point_x       <= px;
      req_chan.point_y       <= py;
      req_chan.min_hot_width <= hot;
      do @(posedge clock); while (!req_chan.ready);
      pending_verdicts.push_back(v);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Result-side ready: random stalls plus long hold-offs on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Compare each accepted result with the oldest expected verdict
   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected item: hit %0b in_band %0b", rsp_chan.hit, rsp_chan.in_band);
            fail_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_chan.hit !== want.hit) begin
               $error("hit: expected %0b, got %0b", want.hit, rsp_chan.hit);
               fail_count++;
            end
            if (rsp_chan.in_band !== want.in_band) begin
               $error("in_band: expected %0b, got %0b", want.in_band, rsp_chan.in_band);
               fail_count++;
            end
         end
      end
   end

   // Run limit
   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("== FAIL ==");
      $finish;
   end

   // Stimulus
   initial begin
      int                        cx, cy, outer, bw, st, sw, span, sel;
      bit                        lm;
      logic signed [COORD_W-1:0] px, py;
      logic [COORD_W-1:0]        hot;
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.point_x       <= '0;
      req_chan.point_y       <= '0;
      req_chan.min_hot_width <= '0;
      csr_chan.valid         <= 1'b0;
      csr_chan.index         <= '0;
      csr_chan.data          <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_WRITE) begin
            write_reg(dir_rows[r].index, dir_rows[r].data);
         end else begin
            send_query(dir_rows[r].px, dir_rows[r].py, dir_rows[r].hot,
                       dir_rows[r].typed, dir_rows[r].want);
         end
      end

      // Random phases, each with its own register setting and idle pattern
      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p)
            0: begin
               cx = 32767; cy = 32767; outer = 65535; bw = 65535;
               st = ANG_FULL; sw = ANG_FULL; lm = 1'b0;
            end
            1: begin
               cx = -32768; cy = -32768; outer = 0; bw = 0;
               st = -ANG_FULL; sw = -ANG_FULL; lm = 1'b1;
            end
            default: begin
               if ($urandom_range(1)) begin
                  cx = int'($urandom_range(4000)) - 2000;
                  cy = int'($urandom_range(4000)) - 2000;
               end else begin
                  cx = int'($urandom_range(65535)) - 32768;
                  cy = int'($urandom_range(65535)) - 32768;
               end
               outer = ($urandom_range(9) == 0) ? 65535 : int'($urandom_range(4000));
               bw = ($urandom_range(3) == 0) ? int'($urandom_range(65535))
                                             : int'($urandom_range(outer));
               st = int'($urandom_range(2 * ANG_FULL)) - ANG_FULL;
               sw = int'($urandom_range(2 * ANG_FULL)) - ANG_FULL;
               lm = $urandom_range(1);
            end
         endcase
         write_reg(arht_pkg::CSR_CENTER_X, 16'(cx));
         write_reg(arht_pkg::CSR_CENTER_Y, 16'(cy));
         write_reg(arht_pkg::CSR_OUTER_RADIUS, 16'(outer));
         write_reg(arht_pkg::CSR_BAND_WIDTH, 16'(bw));
         write_reg(arht_pkg::CSR_START_ANGLE, 16'(st));
         write_reg(arht_pkg::CSR_SWEEP_ANGLE, 16'(sw));
         // upper data bits are don't-care for the mode flag
         write_reg(arht_pkg::CSR_LEFT_MODE, {15'($urandom), lm});
         if (p == 3) write_reg(CSR_IDX_UNUSED, 16'($urandom));

         case (idle_mode_type'(p % 4))
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default:   begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         // long result hold-off so the pipeline backs up into the input
         if (p == 0 || p == 6) rsp_hold_left = HOLD_CYCLES;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            sel  = $urandom_range(99);
            span = int'(cfg_outer) + 64;
            if (sel < 70) begin
               px = clamp_coord(int'(cfg_center_x) + int'($urandom_range(2 * span)) - span);
               py = clamp_coord(int'(cfg_center_y) + int'($urandom_range(2 * span)) - span);
            end else if (sel < 90) begin
               px = 16'($urandom);
               py = 16'($urandom);
            end else if (sel < 95) begin
               px = cfg_center_x;
               py = cfg_center_y;
            end else begin
               // on one of the axes through the center
               px = clamp_coord(int'(cfg_center_x) + int'($urandom_range(2 * span)) - span);
               py = cfg_center_y;
               if ($urandom_range(1)) begin
                  py = clamp_coord(int'(cfg_center_y) + int'($urandom_range(2 * span)) - span);
                  px = cfg_center_x;
               end
            end
            sel = $urandom_range(9);
            if (sel < 5) hot = '0;
            else if (sel < 8) hot = 16'($urandom_range(int'(cfg_outer)));
            else hot = 16'($urandom);
            send_query(px, py, hot, 1'b0, '0);
         end
      end

      // Drain, then give stray results time to show up
      req_chan.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
